### sv/kbsh_pkg.sv
// Shared types, codes and helpers for the keyboard strobe handshake port.
`timescale 1ns / 1ps
`default_nettype none
package kbsh_pkg;

	localparam int DEFAULT_FIFO_DEPTH = 16;
	localparam int CHAR_W = 7;
	localparam int BYTE_W = 8;
	localparam logic [BYTE_W-1:0] DATA_AVAIL = 8'h80;
	localparam logic [BYTE_W-1:0] LOWER_A = 8'h61;
	localparam logic [BYTE_W-1:0] LOWER_Z = 8'h7A;
	localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_ACK = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	typedef enum logic [1:0] {
		HS_IDLE = 2'd0,
		HS_WRITE = 2'd1,
		HS_WAIT = 2'd2,
		HS_POLL = 2'd3
	} hs_state_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic [CHAR_W-1:0] data;
	} fifo_req_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic full_nx;
		logic empty_nx;
		logic [CHAR_W-1:0] head;
	} fifo_stat_t;

	function automatic logic [BYTE_W-1:0] fold_char(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] r;
		r = c;
		if (c >= LOWER_A && c <= LOWER_Z) begin
			r = c - CASE_OFFSET;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/keyboard_strobe_handshake_port_top.sv
// Top level of the keyboard strobe handshake port.
// Path: a word accepted by the input stage is registered there, then processed into the
// output registers once the output can take it (not while a stalled result is held).
// Throughput: one word per cycle; with both registers holding a word, in_ready
// follows out_ready combinationally, so a stalled result holds the input.
// Reset: arst_n clears handshake state, flags, pointers, fill count and outputs;
// the character store is not cleared and holds garbage until written.
`timescale 1ns / 1ps
`default_nettype none
module keyboard_strobe_handshake_port_top #(
	parameter int FIFO_DEPTH = kbsh_pkg::DEFAULT_FIFO_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] command,
	input wire logic [7:0] char_code,
	input wire logic clear_level,
	output logic out_valid,
	input wire logic out_ready,
	output logic [7:0] bus_data,
	output logic strobe_res,
	output logic buffer_full,
	output logic buffer_empty,
	output logic char_dropped
);

	logic valid_s1;
	logic [1:0] command_s1;
	logic [7:0] char_s1;
	logic clear_s1;
	logic adv;

	kbsh_pkg::hs_state_t hs_q, hs_d;
	logic ack_q, ack_d;
	logic [7:0] data_q, data_d;
	logic strobe_q, strobe_d;

	logic [7:0] folded;
	logic push_req, dropped;
	logic is_tick;
	logic pop_req;

	kbsh_pkg::fifo_req_t fifo_req;
	kbsh_pkg::fifo_stat_t fifo_stat;

	assign adv = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1 <= command;
			char_s1 <= char_code;
			clear_s1 <= clear_level;
		end
	end

	assign folded = kbsh_pkg::fold_char(char_s1);
	assign push_req = adv && (command_s1 == kbsh_pkg::CMD_PUSH);
	assign is_tick = adv && (command_s1 == kbsh_pkg::CMD_TICK);
	assign fifo_req.push = push_req && !folded[7] && !fifo_stat.full;
	assign fifo_req.data = folded[kbsh_pkg::CHAR_W-1:0];
	assign fifo_req.pop = pop_req;
	assign dropped = push_req && !fifo_req.push;

	kbsh_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.req(fifo_req),
		.stat(fifo_stat)
	);

	always_comb begin
		hs_d = hs_q;
		if (is_tick) begin
			case (hs_q)
				kbsh_pkg::HS_IDLE: begin
					if (!fifo_stat.empty) begin
						hs_d = kbsh_pkg::HS_WRITE;
					end
				end
				kbsh_pkg::HS_WRITE: hs_d = kbsh_pkg::HS_WAIT;
				kbsh_pkg::HS_WAIT: begin
					if (ack_q) begin
						hs_d = kbsh_pkg::HS_POLL;
					end
				end
				kbsh_pkg::HS_POLL: begin
					if (!clear_s1) begin
						hs_d = kbsh_pkg::HS_IDLE;
					end
				end
				default: hs_d = kbsh_pkg::HS_IDLE;
			endcase
		end
	end

	always_comb begin
		ack_d = ack_q;
		data_d = data_q;
		strobe_d = strobe_q;
		pop_req = 1'b0;
		if (adv && command_s1 == kbsh_pkg::CMD_ACK) begin
			ack_d = 1'b1;
		end
		if (is_tick) begin
			case (hs_q)
				kbsh_pkg::HS_WRITE: begin
					pop_req = !fifo_stat.empty;
					data_d = kbsh_pkg::DATA_AVAIL | {1'b0, (fifo_stat.empty ?
						{kbsh_pkg::CHAR_W{1'b0}} : fifo_stat.head)};
					strobe_d = 1'b1;
				end
				kbsh_pkg::HS_WAIT: begin
					if (ack_q) begin
						strobe_d = 1'b0;
						ack_d = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q <= kbsh_pkg::HS_IDLE;
			ack_q <= 1'b0;
			data_q <= '0;
			strobe_q <= 1'b0;
			out_valid <= 1'b0;
			bus_data <= '0;
			strobe_res <= 1'b0;
			buffer_full <= 1'b0;
			buffer_empty <= 1'b1;
			char_dropped <= 1'b0;
		end else begin
			hs_q <= hs_d;
			ack_q <= ack_d;
			data_q <= data_d;
			strobe_q <= strobe_d;
			if (adv) begin
				out_valid <= 1'b1;
				bus_data <= data_d;
				strobe_res <= strobe_d;
				buffer_full <= fifo_stat.full_nx;
				buffer_empty <= fifo_stat.empty_nx;
				char_dropped <= dropped;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### sv/kbsh_fifo.sv
// Character FIFO with a registered head word and write-to-head bypass.
`timescale 1ns / 1ps
`default_nettype none
module kbsh_fifo #(
	parameter int DEPTH = kbsh_pkg::DEFAULT_FIFO_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire kbsh_pkg::fifo_req_t req,
	output kbsh_pkg::fifo_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [kbsh_pkg::CHAR_W-1:0] mem [DEPTH];
	logic [kbsh_pkg::CHAR_W-1:0] head_q;
	logic [PTR_W-1:0] rd_ptr_q, wr_ptr_q, rd_ptr_d, wr_ptr_d;
	logic [CNT_W-1:0] count_q, count_d;

	always_comb begin
		rd_ptr_d = rd_ptr_q;
		wr_ptr_d = wr_ptr_q;
		count_d = count_q;
		if (req.pop) begin
			rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
		end
		if (req.push) begin
			wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
		end
		case ({req.push, req.pop})
			2'b10: count_d = count_q + 1'b1;
			2'b01: count_d = count_q - 1'b1;
			default: count_d = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q <= '0;
		end else begin
			rd_ptr_q <= rd_ptr_d;
			wr_ptr_q <= wr_ptr_d;
			count_q <= count_d;
		end
	end

	// keep head_q equal to the word at the read pointer
	always_ff @(posedge clk) begin
		if (req.push) begin
			mem[wr_ptr_q] <= req.data;
		end
		if (req.push && wr_ptr_q == rd_ptr_d) begin
			head_q <= req.data;
		end else begin
			head_q <= mem[rd_ptr_d];
		end
	end

	assign stat.full = (count_q == CNT_FULL);
	assign stat.empty = (count_q == '0);
	assign stat.full_nx = (count_d == CNT_FULL);
	assign stat.empty_nx = (count_d == '0);
	assign stat.head = head_q;

endmodule
`default_nettype wire

### sv/kbsh_checker.sv
// Port-level checks for the keyboard strobe handshake port, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module kbsh_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [7:0] bus_data,
	input wire logic strobe_res,
	input wire logic buffer_full,
	input wire logic buffer_empty
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bus_data) && $stable(strobe_res))
		else $error("stalled result word changed");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(buffer_full && buffer_empty))
		else $error("buffer reported full and empty at once");

	a_strobe_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && strobe_res |-> bus_data[7])
		else $error("strobe high without data-available bit");

	a_data_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bus_data != 8'h00 |-> bus_data[7])
		else $error("driven byte lacks data-available bit");

endmodule

bind keyboard_strobe_handshake_port_top kbsh_checker u_kbsh_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.bus_data(bus_data),
	.strobe_res(strobe_res),
	.buffer_full(buffer_full),
	.buffer_empty(buffer_empty)
);
`default_nettype wire

### tb/tb.sv
// Testbench for the keyboard strobe handshake port: directed and random words.
`timescale 1ns / 1ps
module tb;

	localparam int DEPTH = kbsh_pkg::DEFAULT_FIFO_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_WORDS = 1400;
	localparam int QUIET_WORDS = 200;
	localparam int LONG_HOLD = 120;

	typedef struct packed {
		logic [7:0] data;
		logic strobe;
		logic full;
		logic empty;
		logic dropped;
	} port_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] command = kbsh_pkg::CMD_PUSH;
	logic [7:0] char_code = 8'h00;
	logic clear_level = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] bus_data;
	logic strobe_res;
	logic buffer_full;
	logic buffer_empty;
	logic char_dropped;

	port_word_t expected_words[$];
	port_word_t seen_word;
	port_word_t want_word;

	kbsh_pkg::hs_state_t hs_state;
	logic ack_flag;
	logic [kbsh_pkg::CHAR_W-1:0] char_fifo [DEPTH];
	logic [PTR_W-1:0] rd_ptr;
	logic [PTR_W-1:0] wr_ptr;
	logic [PTR_W:0] fifo_count;
	logic [7:0] latch_byte;
	logic strobe_level;

	int mismatches = 0;
	int cycles = 0;
	int words_sent = 0;
	int hold_left = 0;
	int stall_left = 0;
	bit idle_en = 1'b1;

	keyboard_strobe_handshake_port_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.char_code(char_code),
		.clear_level(clear_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.bus_data(bus_data),
		.strobe_res(strobe_res),
		.buffer_full(buffer_full),
		.buffer_empty(buffer_empty),
		.char_dropped(char_dropped)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic port_word_t step_port(input logic [1:0] cmd, input logic [7:0] code,
			input logic clr);
		port_word_t w;
		logic [7:0] c;
		w.dropped = 1'b0;
		c = code;
		case (cmd)
			kbsh_pkg::CMD_PUSH: begin
				if (c >= kbsh_pkg::LOWER_A && c <= kbsh_pkg::LOWER_Z) begin
					c = c - kbsh_pkg::CASE_OFFSET;
				end
				if (c[7] || fifo_count >= DEPTH) begin
					w.dropped = 1'b1;
				end else begin
					char_fifo[wr_ptr] = c[kbsh_pkg::CHAR_W-1:0];
					wr_ptr = PTR_W'((wr_ptr + 1) % DEPTH);
					fifo_count = fifo_count + 1'b1;
				end
			end
			kbsh_pkg::CMD_ACK: begin
				ack_flag = 1'b1;
			end
			kbsh_pkg::CMD_TICK: begin
				case (hs_state)
					kbsh_pkg::HS_IDLE: begin
						if (fifo_count != 0) hs_state = kbsh_pkg::HS_WRITE;
					end
					kbsh_pkg::HS_WRITE: begin
						latch_byte = kbsh_pkg::DATA_AVAIL;
						if (fifo_count != 0) begin
							latch_byte = kbsh_pkg::DATA_AVAIL | {1'b0, char_fifo[rd_ptr]};
							rd_ptr = PTR_W'((rd_ptr + 1) % DEPTH);
							fifo_count = fifo_count - 1'b1;
						end
						strobe_level = 1'b1;
						hs_state = kbsh_pkg::HS_WAIT;
					end
					kbsh_pkg::HS_WAIT: begin
						if (ack_flag) begin
							strobe_level = 1'b0;
							ack_flag = 1'b0;
							hs_state = kbsh_pkg::HS_POLL;
						end
					end
					default: begin
						if (!clr) hs_state = kbsh_pkg::HS_IDLE;
					end
				endcase
			end
			default: begin
			end
		endcase
		w.data = latch_byte;
		w.strobe = strobe_level;
		w.full = (fifo_count >= DEPTH);
		w.empty = (fifo_count == 0);
		return w;
	endfunction

	task automatic send_word(input logic [1:0] cmd, input logic [7:0] code, input logic clr);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		char_code <= code;
		clear_level <= clr;
		do @(posedge clk); while (!in_ready);
		expected_words.push_back(step_port(cmd, code, clr));
		if (cmd != CMD_UNUSED) words_sent++;
	endtask

	task automatic send_noise();
		send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)));
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_words.size() != 0);
	endtask

	// advance the handshake until it is back in idle
	task automatic strobe_one_char();
		do begin
			case (hs_state)
				kbsh_pkg::HS_WAIT: begin
					if (!ack_flag && $urandom_range(0, 2) != 0) begin
						send_word(kbsh_pkg::CMD_ACK, 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)));
					end else begin
						send_word(kbsh_pkg::CMD_TICK, 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)));
					end
				end
				kbsh_pkg::HS_POLL: begin
					send_word(kbsh_pkg::CMD_TICK, 8'($urandom_range(0, 255)),
						$urandom_range(0, 2) == 0);
				end
				default: begin
					send_word(kbsh_pkg::CMD_TICK, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				end
			endcase
		end while (hs_state != kbsh_pkg::HS_IDLE);
	endtask

	task automatic drain_buffer();
		while (fifo_count != 0 || hs_state != kbsh_pkg::HS_IDLE) strobe_one_char();
	endtask

	task automatic test_directed_cases();
		send_word(CMD_UNUSED, 8'hFF, 1'b1);
		send_word(kbsh_pkg::CMD_ACK, 8'h00, 1'b0);
		send_word(kbsh_pkg::CMD_TICK, 8'h00, 1'b0);
		send_word(kbsh_pkg::CMD_PUSH, 8'h00, 1'b0);
		send_word(kbsh_pkg::CMD_PUSH, 8'h7F, 1'b1);
		send_word(kbsh_pkg::CMD_PUSH, 8'h80, 1'b0);
		send_word(kbsh_pkg::CMD_PUSH, 8'hFF, 1'b1);
		send_word(kbsh_pkg::CMD_PUSH, 8'h61, 1'b0);
		send_word(kbsh_pkg::CMD_PUSH, 8'h7A, 1'b0);
		send_word(kbsh_pkg::CMD_PUSH, 8'h60, 1'b0);
		send_word(kbsh_pkg::CMD_PUSH, 8'h7B, 1'b0);
		send_word(kbsh_pkg::CMD_PUSH, 8'h41, 1'b0);
		send_word(kbsh_pkg::CMD_PUSH, 8'h5A, 1'b0);
		send_word(kbsh_pkg::CMD_TICK, 8'h00, 1'b1);
		send_word(kbsh_pkg::CMD_TICK, 8'hFF, 1'b1);
		send_word(kbsh_pkg::CMD_TICK, 8'h00, 1'b1);
		send_word(kbsh_pkg::CMD_TICK, 8'h00, 1'b1);
		send_word(kbsh_pkg::CMD_TICK, 8'h00, 1'b0);
		send_word(kbsh_pkg::CMD_TICK, 8'h00, 1'b0);
		send_word(kbsh_pkg::CMD_TICK, 8'h00, 1'b0);
		send_word(kbsh_pkg::CMD_TICK, 8'h00, 1'b0);
		send_word(kbsh_pkg::CMD_ACK, 8'hFF, 1'b1);
		send_word(kbsh_pkg::CMD_TICK, 8'h00, 1'b1);
		send_word(kbsh_pkg::CMD_TICK, 8'h00, 1'b0);
		send_word(CMD_UNUSED, 8'h00, 1'b0);
	endtask

	task automatic test_full_buffer();
		repeat (DEPTH + 4) send_word(kbsh_pkg::CMD_PUSH, 8'($urandom_range(8'h20, 8'h7F)),
			1'($urandom_range(0, 1)));
		send_word(kbsh_pkg::CMD_PUSH, 8'h00, 1'b0);
		send_word(kbsh_pkg::CMD_ACK, 8'h00, 1'b0);
		drain_buffer();
	endtask

	task automatic test_output_backpressure();
		hold_left = LONG_HOLD;
		repeat (10) send_word(kbsh_pkg::CMD_PUSH, 8'($urandom_range(8'h20, 8'h7F)),
			1'($urandom_range(0, 1)));
		drain_buffer();
	endtask

	task automatic test_random_sessions(input int count);
		int target;
		int burst;
		target = words_sent + count;
		while (words_sent < target) begin
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(3, 10)) send_noise();
			end else begin
				burst = ($urandom_range(0, 9) == 0) ? $urandom_range(12, DEPTH + 4)
					: $urandom_range(1, 6);
				repeat (burst) begin
					if ($urandom_range(0, 4) == 0) begin
						send_word(kbsh_pkg::CMD_PUSH, 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)));
					end else begin
						send_word(kbsh_pkg::CMD_PUSH, 8'($urandom_range(8'h20, 8'h7F)),
							1'($urandom_range(0, 1)));
					end
				end
				repeat (burst) begin
					if ($urandom_range(0, 7) == 0) send_noise();
					strobe_one_char();
				end
			end
		end
		drain_buffer();
	endtask

	task automatic test_quiet_finish();
		idle_en = 1'b0;
		test_random_sessions(QUIET_WORDS);
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			stall_left = $urandom_range(0, 4);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_word = {bus_data, strobe_res, buffer_full, buffer_empty, char_dropped};
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected word: data %h strobe %b full %b empty %b dropped %b",
						seen_word.data, seen_word.strobe, seen_word.full, seen_word.empty,
						seen_word.dropped);
				end
			end else begin
				want_word = expected_words.pop_front();
				if (seen_word.data !== want_word.data || seen_word.strobe !== want_word.strobe
						|| seen_word.full !== want_word.full
						|| seen_word.empty !== want_word.empty
						|| seen_word.dropped !== want_word.dropped) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected data %h strobe %b full %b empty %b dropped %b",
							want_word.data, want_word.strobe, want_word.full, want_word.empty,
							want_word.dropped);
						$display("          actual   data %h strobe %b full %b empty %b dropped %b",
							seen_word.data, seen_word.strobe, seen_word.full, seen_word.empty,
							seen_word.dropped);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		hs_state = kbsh_pkg::HS_IDLE;
		ack_flag = 1'b0;
		rd_ptr = '0;
		wr_ptr = '0;
		fifo_count = '0;
		latch_byte = 8'h00;
		strobe_level = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		wait_all_results();
		test_full_buffer();
		wait_all_results();
		test_output_backpressure();
		wait_all_results();
		test_random_sessions(RANDOM_WORDS);
		wait_all_results();
		test_quiet_finish();
		wait_all_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
